>>> rtl/mm4_pkg.sv
package mm4_pkg;

  // Item codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_MULTIPLY = 1'b1;

  localparam logic TGT_LEFT  = 1'b0;
  localparam logic TGT_RIGHT = 1'b1;

  // Inner index of the last partial product of one dot product
  localparam logic [1:0] K_LAST   = 2'd3;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef struct packed {
    logic        op;
    logic        target;
    logic [3:0]  position;
    logic [31:0] element;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  out_position;
    logic [31:0] product_value;
    logic        clipped;
    logic        last;
  } out_beat_t;

  // Control tag that travels with one left element along the chain
  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic [1:0] k;
  } tok_t;

endpackage

>>> rtl/mm4_cell.sv
module mm4_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int COL        = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              wr_i,
  input  logic [3:0]                        wr_pos_i,
  input  logic [ELEM_WIDTH-1:0]             wr_data_i,
  input  mm4_pkg::tok_t                     tok_i,
  input  logic [ELEM_WIDTH-1:0]             a_i,
  output mm4_pkg::tok_t                     tok_o,
  output logic [ELEM_WIDTH-1:0]             a_o,
  output logic                              done_o,
  output logic [1:0]                        row_o,
  output logic [2*ELEM_WIDTH+1:0]           acc_o
);

  localparam int ProdW = 2 * ELEM_WIDTH;
  localparam int AccW  = ProdW + 2;
  localparam logic [1:0] ColId = COL[1:0];

  // One column of the right matrix, indexed by k
  logic [ELEM_WIDTH-1:0] col_q [4];

  mm4_pkg::tok_t         tok_q;
  logic [ELEM_WIDTH-1:0] a_q;
  logic [ProdW-1:0]      prod_q;
  logic [AccW-1:0]       acc_q, acc_d;
  logic                  done_q;
  logic [1:0]            row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        col_q[i] <= '0;
      end
    end else if (wr_i && wr_pos_i[1:0] == ColId) begin
      col_q[wr_pos_i[3:2]] <= wr_data_i;
    end
  end

  always_comb begin
    acc_d = (tok_q.k == 2'd0) ? '0 : acc_q;
    acc_d = acc_d + AccW'($signed(prod_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      done_q <= 1'b0;
      row_q  <= '0;
    end else if (adv_i) begin
      tok_q  <= tok_i;
      done_q <= tok_q.valid && tok_q.k == mm4_pkg::K_LAST;
      row_q  <= tok_q.row;
    end
  end

  // Datapath: multiply this beat, accumulate the previous one
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_q    <= a_i;
      prod_q <= ProdW'($signed(a_i)) * ProdW'($signed(col_q[tok_i.k]));
      if (tok_q.valid) begin
        acc_q <= acc_d;
      end
    end
  end

  assign tok_o  = tok_q;
  assign a_o    = a_q;
  assign done_o = done_q;
  assign row_o  = row_q;
  assign acc_o  = acc_q;

endmodule

>>> rtl/matrix4x4_multiply.sv
// Load item: stored in the addressed matrix, no result.
// Multiply item: product elements come out one element per cycle while out_ready_i does not stall,
// from a chain of four multiply-accumulate cells (one per column);
// no new item is taken until the last element has entered the output register.
// Reset clears both matrices to zero and empties the chain and the output register.
module matrix4x4_multiply #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mm4_pkg::in_beat_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mm4_pkg::out_beat_t out_o
);

  localparam int AccW = 2 * ELEM_WIDTH + 2;
  localparam int HiW  = AccW - ELEM_WIDTH + 1;
  localparam logic signed [ELEM_WIDTH-1:0] MaxV = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic signed [ELEM_WIDTH-1:0] MinV = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  logic                  adv;
  logic                  in_acc;
  logic                  busy_q, feeding_q;
  logic [3:0]            cnt_q;
  logic [ELEM_WIDTH-1:0] left_q [16];
  mm4_pkg::tok_t         feed_tok_q;
  logic [ELEM_WIDTH-1:0] feed_a_q;

  mm4_pkg::tok_t         tok   [5];
  logic [ELEM_WIDTH-1:0] a     [5];
  logic [3:0]            done;
  logic [1:0]            row   [4];
  logic [AccW-1:0]       acc   [4];

  logic                  out_valid_q;
  mm4_pkg::out_beat_t    out_q, out_d;
  logic                  any_done;
  logic signed [AccW-1:0] acc_sel, sh;
  logic [HiW-1:0]        hi;
  logic                  ovf;
  logic signed [ELEM_WIDTH-1:0] sat_v;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Left matrix and feed sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        left_q[i] <= '0;
      end
      busy_q     <= 1'b0;
      feeding_q  <= 1'b0;
      cnt_q      <= '0;
      feed_tok_q <= '0;
    end else begin
      if (in_acc && in_i.op == mm4_pkg::OP_LOAD && in_i.target == mm4_pkg::TGT_LEFT) begin
        left_q[in_i.position] <= in_i.element[ELEM_WIDTH-1:0];
      end
      if (in_acc && in_i.op == mm4_pkg::OP_MULTIPLY) begin
        busy_q    <= 1'b1;
        feeding_q <= 1'b1;
        cnt_q     <= '0;
      end else begin
        if (adv && done[3] && row[3] == mm4_pkg::ROW_LAST) begin
          busy_q <= 1'b0;
        end
        if (adv && feeding_q) begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            feeding_q <= 1'b0;
          end
        end
      end
      if (adv) begin
        feed_tok_q.valid <= feeding_q;
        feed_tok_q.row   <= cnt_q[3:2];
        feed_tok_q.k     <= cnt_q[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      feed_a_q <= left_q[cnt_q];
    end
  end

  assign tok[0] = feed_tok_q;
  assign a[0]   = feed_a_q;

  for (genvar c = 0; c < 4; c++) begin : g_cell
    mm4_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .COL       (c)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .wr_i     (in_acc && in_i.op == mm4_pkg::OP_LOAD &&
                 in_i.target == mm4_pkg::TGT_RIGHT),
      .wr_pos_i (in_i.position),
      .wr_data_i(in_i.element[ELEM_WIDTH-1:0]),
      .tok_i    (tok[c]),
      .a_i      (a[c]),
      .tok_o    (tok[c+1]),
      .a_o      (a[c+1]),
      .done_o   (done[c]),
      .row_o    (row[c]),
      .acc_o    (acc[c])
    );
  end

  // Pick the finishing cell; the chain skew makes at most one finish per cycle
  always_comb begin
    acc_sel = '0;
    out_d   = '0;
    for (int c = 0; c < 4; c++) begin
      if (done[c]) begin
        acc_sel            = acc[c];
        out_d.out_position = {row[c], 2'(c)};
        out_d.last         = (row[c] == mm4_pkg::ROW_LAST) && (c == 3);
      end
    end
    sh    = acc_sel >>> FRAC_BITS;
    hi    = sh[AccW-1:ELEM_WIDTH-1];
    ovf   = !((&hi) || !(|hi));
    sat_v = ovf ? (sh[AccW-1] ? MinV : MaxV) : sh[ELEM_WIDTH-1:0];
    out_d.product_value = 32'(sat_v);
    out_d.clipped       = ovf;
  end

  assign any_done = |done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= any_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done))
    else $error("more than one cell finished in a cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_done |-> busy_q)
    else $error("cell finished outside a multiply");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !feeding_q && !feed_tok_q.valid)
    else $error("ready while the chain is still fed");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.clipped |->
      out_o.product_value == 32'(MaxV) || out_o.product_value == 32'(MinV))
    else $error("clipped element is not a limit value");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int STUCK_LIMIT = 3000;

  // Tracks both operand matrices and queues the sixteen product beats that each
  // multiply must produce.
  class product_board;
    logic signed [31:0] left_m[16];
    logic signed [31:0] right_m[16];
    mm4_pkg::out_beat_t pending_q[$];
    int failures;
    int received;

    function new();
      foreach (left_m[i]) begin
        left_m[i] = '0;
        right_m[i] = '0;
      end
      failures = 0;
      received = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function mm4_pkg::out_beat_t product_element(int idx);
      logic signed [65:0] acc;
      logic signed [65:0] lf;
      logic signed [65:0] rt;
      logic signed [65:0] maxv;
      logic signed [65:0] minv;
      mm4_pkg::out_beat_t e;
      acc = '0;
      maxv = (66'sd1 <<< (ELEM_WIDTH - 1)) - 66'sd1;
      minv = -maxv - 66'sd1;
      for (int k = 0; k < 4; k++) begin
        lf = left_m[(idx / 4) * 4 + k];
        rt = right_m[k * 4 + idx % 4];
        acc += lf * rt;
      end
      // floor division by the fraction scale
      acc = acc >>> FRAC_BITS;
      e.clipped = 1'b0;
      if (acc > maxv) begin
        acc = maxv;
        e.clipped = 1'b1;
      end else if (acc < minv) begin
        acc = minv;
        e.clipped = 1'b1;
      end
      e.product_value = acc[31:0];
      e.out_position = 4'(idx);
      e.last = (idx == 15);
      return e;
    endfunction

    function void note_beat(mm4_pkg::in_beat_t b);
      logic signed [31:0] v;
      if (b.op == mm4_pkg::OP_LOAD) begin
        v = b.element;
        // keep the low ELEM_WIDTH bits as two's complement
        v = (v <<< (32 - ELEM_WIDTH)) >>> (32 - ELEM_WIDTH);
        if (b.target == mm4_pkg::TGT_LEFT) begin
          left_m[b.position] = v;
        end else begin
          right_m[b.position] = v;
        end
      end else begin
        for (int idx = 0; idx < 16; idx++) pending_q.push_back(product_element(idx));
      end
    endfunction

    function void check_beat(mm4_pkg::out_beat_t got);
      mm4_pkg::out_beat_t want;
      received++;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: unexpected product beat pos=%0d value=%h clipped=%b last=%b",
                   $realtime, got.out_position, got.product_value, got.clipped, got.last);
        end
        return;
      end
      want = pending_q.pop_front();
      if (got.out_position !== want.out_position ||
          got.product_value !== want.product_value ||
          got.clipped !== want.clipped || got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: product beat differs: expected pos=%0d value=%h clipped=%b last=%b",
                   $realtime, want.out_position, want.product_value, want.clipped, want.last);
          $display("%0t:                       actual   pos=%0d value=%h clipped=%b last=%b",
                   $realtime, got.out_position, got.product_value, got.clipped, got.last);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  mm4_pkg::in_beat_t  in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  mm4_pkg::out_beat_t out_o;

  product_board sb;

  matrix4x4_multiply #(
    .FRAC_BITS (FRAC_BITS),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_element();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2: return $urandom();
      default: return 32'($urandom_range(0, 1 << 19)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic mm4_pkg::in_beat_t make_beat(logic op, logic tgt, logic [3:0] pos,
                                                  logic [31:0] elem);
    mm4_pkg::in_beat_t b;
    b.op = op;
    b.target = tgt;
    b.position = pos;
    b.element = elem;
    return b;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input mm4_pkg::in_beat_t b);
    in_i <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(b);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  initial begin : result_sink
    int stall;
    int cyc;
    bit long_done;
    stall = 0;
    cyc = 0;
    long_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      // fill the block once by refusing results for a long stretch
      if (!long_done && sb.received >= 40) begin
        long_done = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ((cyc / 250) % 4 != 3) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_beat(out_o);
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    wait (rst_ni);
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    mm4_pkg::in_beat_t plan[$];
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // product of the cleared matrices, with junk in the ignored fields
    plan.push_back(make_beat(mm4_pkg::OP_MULTIPLY, mm4_pkg::TGT_RIGHT, 4'd15, 32'hffff_ffff));
    // row 0 and column 0 at the maximum: clip high in element 0
    for (int i = 0; i < 4; i++) begin
      plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_LEFT, 4'(i), 32'h7fff_ffff));
      plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_RIGHT, 4'(i * 4),
                               32'h7fff_ffff));
    end
    // min times max: clip low in element 15
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_LEFT, 4'd15, 32'h8000_0000));
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_RIGHT, 4'd15, 32'h7fff_ffff));
    // small negative sum: shift rounds toward minus infinity
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_LEFT, 4'd5, 32'hffff_ffff));
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_RIGHT, 4'd5, 32'h0001_0000));
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_LEFT, 4'd6, 32'hffff_ffff));
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_RIGHT, 4'd9, 32'h0000_0001));
    // min times min gives the largest positive product
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_LEFT, 4'd10, 32'h8000_0000));
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_RIGHT, 4'd10, 32'h8000_0000));
    plan.push_back(make_beat(mm4_pkg::OP_MULTIPLY, mm4_pkg::TGT_LEFT, 4'd0, 32'h0000_0000));
    plan.push_back(make_beat(mm4_pkg::OP_LOAD, mm4_pkg::TGT_LEFT, 4'd0, 32'h8000_0000));
    plan.push_back(make_beat(mm4_pkg::OP_MULTIPLY, mm4_pkg::TGT_LEFT, 4'd7, 32'h1234_5678));

    for (int n = 0; n < 240; n++) begin
      plan.push_back(make_beat(($urandom_range(0, 6) == 0) ? mm4_pkg::OP_MULTIPLY
                                                            : mm4_pkg::OP_LOAD,
                               1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                               random_element()));
    end

    for (int i = 0; i < plan.size(); i++) begin
      if (i == 140) begin
        // drain completely before going on
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      send_beat(plan[i]);
      if ((i / 40) % 3 != 2) idle_cycles(pick_gap());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/mm4_pkg.sv
rtl/mm4_cell.sv
rtl/matrix4x4_multiply.sv
verif/testbench.sv
